[src/cor_pkg.sv]
// Package: shared constants, widths and job type for the circle outline rasterizer.
`timescale 1ns / 1ps

package cor_pkg;

  // Frame geometry
  localparam int SCREEN_WIDTH = 320;
  localparam int FRAME_PIXELS = 64000;

  // Field and state widths
  localparam int COORD_W = 16;
  localparam int COLOR_W = 8;
  localparam int OFF_W   = 17;
  localparam int DEC_W   = 20;

  // Linear index width: wide enough for any width*row+col and for the frame size
  localparam int IDX_RAW_W = $clog2((SCREEN_WIDTH + 1) * 65536);
  localparam int FRAME_W   = $clog2(FRAME_PIXELS + 1);
  localparam int IDX_W     = (IDX_RAW_W > FRAME_W) ? IDX_RAW_W : FRAME_W;

  // Midpoint decision constants
  localparam int DEC_INIT      = 3;
  localparam int DEC_INC_MOVE  = 10;
  localparam int DEC_INC_STAY  = 6;

  // Eight mirrored pixels per point
  localparam int MIRRORS   = 8;
  localparam int MIRROR_W  = $clog2(MIRRORS);

  // Job queue depth
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Request codes
  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_t;

  // One point to plot, handed from the front to the back
  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               done;
    logic               nop;    // advance while idle: one non-writing word
  } cor_job_t;

  // One result word
  typedef struct packed {
    logic [COORD_W-1:0] pixel_index;
    logic               write_enable;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_of_step;
    logic               circle_done;
  } cor_pix_t;

endpackage

[src/cor_if.sv]
// Interfaces: request channel and pixel channel with valid/ready handshake.
`timescale 1ns / 1ps

interface cor_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [cor_pkg::COORD_W-1:0]   center_x;
  logic [cor_pkg::COORD_W-1:0]   center_y;
  logic [cor_pkg::COORD_W-1:0]   radius;
  logic [cor_pkg::COLOR_W-1:0]   pen_color;

  modport source (output valid, req_type, center_x, center_y, radius, pen_color,
                  input ready);
  modport sink   (input valid, req_type, center_x, center_y, radius, pen_color,
                  output ready);
endinterface

interface cor_out_if;
  logic                          valid;
  logic                          ready;
  logic [cor_pkg::COORD_W-1:0]   pixel_index;
  logic                          write_enable;
  logic [cor_pkg::COLOR_W-1:0]   pixel_color;
  logic                          last_of_step;
  logic                          circle_done;

  modport source (output valid, pixel_index, write_enable, pixel_color, last_of_step,
                  circle_done, input ready);
  modport sink   (input valid, pixel_index, write_enable, pixel_color, last_of_step,
                  circle_done, output ready);
endinterface

[src/cor_front.sv]
// Front: accepts requests, runs the midpoint step, and queues one point per word.
`timescale 1ns / 1ps

module cor_front (
  input  logic               clk,
  input  logic               rst_n,
  cor_in_if.sink             in_ch,
  input  logic               q_full,
  output logic               q_push,
  output cor_pkg::cor_job_t  q_job
);

  logic [cor_pkg::COORD_W-1:0] center_col_r, center_col_nxt;
  logic [cor_pkg::COORD_W-1:0] center_row_r, center_row_nxt;
  logic [cor_pkg::COLOR_W-1:0] held_color_r, held_color_nxt;
  logic [cor_pkg::OFF_W-1:0]   offset_x_r, offset_x_nxt;
  logic [cor_pkg::OFF_W-1:0]   offset_y_r, offset_y_nxt;
  logic [cor_pkg::DEC_W-1:0]   decision_r, decision_nxt;
  logic                        busy_r, busy_nxt;

  logic                        accept;
  logic [cor_pkg::OFF_W-1:0]   step_x;
  logic [cor_pkg::OFF_W-1:0]   step_y;
  logic signed [cor_pkg::DEC_W-1:0] step_xe;
  logic signed [cor_pkg::DEC_W-1:0] step_ye;
  logic                        dec_pos;
  logic [cor_pkg::DEC_W-1:0]   step_dec;
  logic                        step_done;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // Midpoint step on the held point
  always_comb begin
    step_x  = offset_x_r + cor_pkg::OFF_W'(1);
    dec_pos = !decision_r[cor_pkg::DEC_W-1] && (decision_r != '0);
    step_y  = dec_pos ? (offset_y_r - cor_pkg::OFF_W'(1)) : offset_y_r;
    step_xe = cor_pkg::DEC_W'(signed'(step_x));
    step_ye = cor_pkg::DEC_W'(signed'(step_y));
    if (dec_pos) begin
      step_dec = decision_r + cor_pkg::DEC_W'((step_xe - step_ye) <<< 2)
               + cor_pkg::DEC_W'(cor_pkg::DEC_INC_MOVE);
    end else begin
      step_dec = decision_r + cor_pkg::DEC_W'(step_xe <<< 2)
               + cor_pkg::DEC_W'(cor_pkg::DEC_INC_STAY);
    end
    step_done = signed'(step_y) < signed'(step_x);
  end

  // Next state and queued job
  always_comb begin
    center_col_nxt = center_col_r;
    center_row_nxt = center_row_r;
    held_color_nxt = held_color_r;
    offset_x_nxt   = offset_x_r;
    offset_y_nxt   = offset_y_r;
    decision_nxt   = decision_r;
    busy_nxt       = busy_r;
    q_job          = '0;
    q_job.nop      = 1'b1;
    q_job.done     = 1'b1;
    if (cor_pkg::req_t'(in_ch.req_type) == cor_pkg::REQ_START) begin
      center_col_nxt = in_ch.center_x;
      center_row_nxt = in_ch.center_y;
      held_color_nxt = in_ch.pen_color;
      offset_x_nxt   = '0;
      offset_y_nxt   = cor_pkg::OFF_W'(in_ch.radius);
      decision_nxt   = cor_pkg::DEC_W'(cor_pkg::DEC_INIT)
                     - (cor_pkg::DEC_W'(in_ch.radius) << 1);
      busy_nxt       = 1'b1;
      q_job.nop      = 1'b0;
      q_job.done     = 1'b0;
    end else if (busy_r) begin
      offset_x_nxt   = step_x;
      offset_y_nxt   = step_y;
      decision_nxt   = step_dec;
      busy_nxt       = !step_done;
      q_job.nop      = 1'b0;
      q_job.done     = step_done;
    end
    q_job.cx    = center_col_nxt;
    q_job.cy    = center_row_nxt;
    q_job.x     = offset_x_nxt[cor_pkg::COORD_W-1:0];
    q_job.y     = offset_y_nxt[cor_pkg::COORD_W-1:0];
    q_job.color = held_color_nxt;
  end

  assign q_push = accept;

  // Update circle state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_col_r <= '0;
      center_row_r <= '0;
      held_color_r <= '0;
      offset_x_r   <= '0;
      offset_y_r   <= '0;
      decision_r   <= '0;
      busy_r       <= 1'b0;
    end else if (accept) begin
      center_col_r <= center_col_nxt;
      center_row_r <= center_row_nxt;
      held_color_r <= held_color_nxt;
      offset_x_r   <= offset_x_nxt;
      offset_y_r   <= offset_y_nxt;
      decision_r   <= decision_nxt;
      busy_r       <= busy_nxt;
    end
  end

endmodule

[src/cor_queue.sv]
// Queue: short FIFO of point jobs between the front and the back.
`timescale 1ns / 1ps

module cor_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cor_pkg::cor_job_t  push_job,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output cor_pkg::cor_job_t  head_job
);

  cor_pkg::cor_job_t           mem_r [cor_pkg::QDEPTH];
  logic [cor_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [cor_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [cor_pkg::QCNT_W-1:0]  count_r, count_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign full       = (count_r == cor_pkg::QCNT_W'(cor_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == cor_pkg::QPTR_W'(cor_pkg::QDEPTH - 1))
                 ? '0 : wr_ptr_r + cor_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == cor_pkg::QPTR_W'(cor_pkg::QDEPTH - 1))
                 ? '0 : rd_ptr_r + cor_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + cor_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - cor_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[src/cor_back.sv]
// Back: expands each queued point into its mirrored pixel words.
`timescale 1ns / 1ps

module cor_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  cor_pkg::cor_job_t  head_job,
  output logic               pop,
  cor_out_if.source          out_ch
);

  logic [cor_pkg::MIRROR_W-1:0] mirror_r, mirror_nxt;
  cor_pkg::cor_pix_t            pix_r, pix_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic                         load;
  logic                         last;
  logic [cor_pkg::COORD_W-1:0]  off_col;
  logic [cor_pkg::COORD_W-1:0]  off_row;
  logic [cor_pkg::COORD_W-1:0]  col;
  logic [cor_pkg::COORD_W-1:0]  row;
  logic [cor_pkg::IDX_W-1:0]    idx;
  logic                         in_frame;

  assign load = head_valid && (!out_valid_r || out_ch.ready);
  assign last = head_job.nop
             || (mirror_r == cor_pkg::MIRROR_W'(cor_pkg::MIRRORS - 1));
  assign pop  = load && last;

  // Pick the mirrored coordinate: bit 2 swaps x/y, bit 0 flips column, bit 1 flips row
  always_comb begin
    off_col  = mirror_r[2] ? head_job.y : head_job.x;
    off_row  = mirror_r[2] ? head_job.x : head_job.y;
    col      = mirror_r[0] ? (head_job.cx - off_col) : (head_job.cx + off_col);
    row      = mirror_r[1] ? (head_job.cy - off_row) : (head_job.cy + off_row);
    idx      = cor_pkg::IDX_W'(cor_pkg::SCREEN_WIDTH) * cor_pkg::IDX_W'(row)
             + cor_pkg::IDX_W'(col);
    in_frame = idx < cor_pkg::IDX_W'(cor_pkg::FRAME_PIXELS);
  end

  // Build the next pixel word
  always_comb begin
    pix_nxt              = pix_r;
    if (load) begin
      pix_nxt.last_of_step = last;
      pix_nxt.circle_done  = head_job.done;
      if (head_job.nop) begin
        pix_nxt.pixel_index  = '0;
        pix_nxt.write_enable = 1'b0;
        pix_nxt.pixel_color  = '0;
      end else begin
        pix_nxt.pixel_index  = in_frame ? idx[cor_pkg::COORD_W-1:0] : '0;
        pix_nxt.write_enable = in_frame;
        pix_nxt.pixel_color  = head_job.color;
      end
    end
  end

  // Advance the mirror counter and output valid
  always_comb begin
    mirror_nxt    = mirror_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      mirror_nxt    = last ? '0 : mirror_r + cor_pkg::MIRROR_W'(1);
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mirror_r    <= mirror_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the output word
  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_index  = pix_r.pixel_index;
  assign out_ch.write_enable = pix_r.write_enable;
  assign out_ch.pixel_color  = pix_r.pixel_color;
  assign out_ch.last_of_step = pix_r.last_of_step;
  assign out_ch.circle_done  = pix_r.circle_done;

endmodule

[src/circle_outline_rasterizer_top.sv]
// Top level: circle outline rasterizer with request front, job queue and pixel back.
//
// Usage: send request words on in_ch. A start word (req_type 0) loads center,
// radius and color and yields the eight mirrored pixels of the top point; an
// advance word (req_type 1) takes one midpoint step and yields eight more. An
// advance with no circle running yields a single non-writing word. Pixel words
// leave on out_ch with the frame index, write enable, color, last_of_step on
// the final word of each request and circle_done once the outline is closed.
// The first pixel word of a request passes through the job queue and the
// output register. The back issues one pixel word per cycle while out_ch.ready
// is high, eight words per request (one for an idle advance). The front takes
// a request every cycle while the four-entry job queue has room, so a burst
// of up to four requests enters while pixels still drain.
// Reset (rst_n low, synchronous) empties the queue and output register and
// leaves no circle running. When out_ch.ready is low the current word holds,
// the back stops, and the front keeps taking requests until the queue fills.
`timescale 1ns / 1ps

module circle_outline_rasterizer_top (
  input  logic       clk,
  input  logic       rst_n,
  cor_in_if.sink     in_ch,
  cor_out_if.source  out_ch
);

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  cor_pkg::cor_job_t  q_in_job;
  cor_pkg::cor_job_t  q_head_job;

  cor_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_in_job)
  );

  cor_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_in_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head_job)
  );

  cor_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

endmodule
